// ===== design/bhe_pkg.sv =====
`timescale 1ns / 1ps

package bhe_pkg;

  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] COMMA  = 8'h2C;

  localparam logic       DIR_ENCODE = 1'b0;
  localparam logic       DIR_DECODE = 1'b1;
  localparam logic       ACT_DATA   = 1'b0;
  localparam logic       ACT_EOS    = 1'b1;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       bad_escape;
  } result_t;

  // all results of one input item, up to three
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } bundle_t;

  // emitter status toward the top level
  typedef struct packed {
    logic load_ok;
    logic pend_busy;
  } emit_stat_t;

endpackage

// ===== design/backslash_hex_escape_codec.sv =====
`timescale 1ns / 1ps
// channel   direction  beat contents
// s_*       in         s_tdata = data_byte, s_tuser = action
// m_*       out        m_tdata = out_byte, m_tuser = {bad_escape, byte_valid}, m_tlast
// cfg_*     in         cfg_data = direction
//
// an input beat is registered, then decoded combinationally into up to three result
// beats; the output register sends one beat per cycle while m_tready is high, and
// an escaped byte gives three result beats when encoding. the next item is taken
// only once the last item's leftover beats are in the output register. rst is
// synchronous and clears the direction to encode and the escape state. a stalled
// m_tready holds the output register and backs up via the input register to s_tready.

module backslash_hex_escape_codec
  import bhe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tuser,   // action
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic [1:0] m_tuser,   // byte_valid, bad_escape
  output logic       m_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic       in_valid;
  logic       in_action;
  logic [7:0] in_data;
  logic       proc;
  bundle_t    bundle;
  emit_stat_t stat;

  assign proc      = in_valid && stat.load_ok;
  assign s_tready  = !in_valid || proc;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_data   <= s_tdata;
    end
  end

  bhe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_dir   (cfg_data),
    .step      (proc),
    .action    (in_action),
    .data_byte (in_data),
    .bundle    (bundle)
  );

  bhe_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (proc),
    .bundle   (bundle),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // leftover result beats always sit behind a valid output beat
  a_pend_has_out: assert property (@(posedge clk) disable iff (rst)
    stat.pend_busy |-> m_tvalid)
    else $error("pending results without a valid output beat");

  // a held input item is not dropped
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !s_tready |=> in_valid)
    else $error("stalled input item lost");

  // an accepted beat lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted beat not registered");
`endif

endmodule

// ===== design/bhe_core.sv =====
`timescale 1ns / 1ps

module bhe_core
  import bhe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_dir,
  input  logic       step,
  input  logic       action,
  input  logic [7:0] data_byte,
  output bundle_t    bundle
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SLASH = 2'd1,
    PH_FIRST = 2'd2
  } phase_t;

  logic       direction;
  phase_t     escape_phase, escape_phase_next;
  logic [7:0] first_hex_char, first_hex_char_next;
  logic [7:0] nib_hi;

  function automatic logic is_plain(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == "." || c == "/" || c == "_";
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'd55 + {4'd0, v});
  endfunction

  // wraps mod 256 for non-hex characters
  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= "0" && c <= "9") return c - 8'h30;
    if (c >= "a" && c <= "z") u = c - 8'd32;
    return u - 8'd55;
  endfunction

  function automatic result_t mk(input logic [7:0] b, input logic v,
                                 input logic l, input logic bad);
    result_t r;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.last_of_run = l;
    r.bad_escape  = bad;
    return r;
  endfunction

  assign nib_hi = nibble_of(first_hex_char);

  always_comb begin
    bundle              = '0;
    escape_phase_next   = escape_phase;
    first_hex_char_next = first_hex_char;
    if (direction == DIR_ENCODE) begin
      if (action == ACT_EOS) begin
        bundle.cnt = 2'd1;
        bundle.r0  = mk(COMMA, 1'b1, 1'b1, 1'b0);
      end else if (is_plain(data_byte)) begin
        bundle.cnt = 2'd1;
        bundle.r0  = mk(data_byte, 1'b1, 1'b1, 1'b0);
      end else if (data_byte == BSLASH) begin
        bundle.cnt = 2'd2;
        bundle.r0  = mk(BSLASH, 1'b1, 1'b0, 1'b0);
        bundle.r1  = mk(BSLASH, 1'b1, 1'b1, 1'b0);
      end else begin
        bundle.cnt = 2'd3;
        bundle.r0  = mk(BSLASH, 1'b1, 1'b0, 1'b0);
        bundle.r1  = mk(hex_digit(data_byte[7:4]), 1'b1, 1'b0, 1'b0);
        bundle.r2  = mk(hex_digit(data_byte[3:0]), 1'b1, 1'b1, 1'b0);
      end
    end else if (action == ACT_EOS) begin
      bundle.cnt = 2'd1;
      bundle.r0  = mk(8'h00, 1'b0, 1'b1,
                      escape_phase == PH_SLASH || escape_phase == PH_FIRST);
      escape_phase_next   = PH_IDLE;
      first_hex_char_next = 8'h00;
    end else begin
      case (escape_phase)
        PH_SLASH: begin
          if (data_byte == BSLASH) begin
            bundle.cnt        = 2'd1;
            bundle.r0         = mk(BSLASH, 1'b1, 1'b1, 1'b0);
            escape_phase_next = PH_IDLE;
          end else begin
            first_hex_char_next = data_byte;
            escape_phase_next   = PH_FIRST;
          end
        end
        PH_FIRST: begin
          bundle.cnt = 2'd1;
          bundle.r0  = mk({nib_hi[3:0], 4'h0} + nibble_of(data_byte),
                          1'b1, 1'b1, 1'b0);
          escape_phase_next   = PH_IDLE;
          first_hex_char_next = 8'h00;
        end
        default: begin
          if (data_byte == BSLASH) begin
            escape_phase_next = PH_SLASH;
          end else begin
            bundle.cnt        = 2'd1;
            bundle.r0         = mk(data_byte, 1'b1, 1'b1, 1'b0);
            escape_phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction      <= DIR_ENCODE;
      escape_phase   <= PH_IDLE;
      first_hex_char <= 8'h00;
    end else if (cfg_we) begin
      direction      <= cfg_dir;
      escape_phase   <= PH_IDLE;
      first_hex_char <= 8'h00;
    end else if (step) begin
      escape_phase   <= escape_phase_next;
      first_hex_char <= first_hex_char_next;
    end
  end

endmodule

// ===== design/bhe_emit.sv =====
`timescale 1ns / 1ps

module bhe_emit
  import bhe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  bundle_t    bundle,
  output emit_stat_t stat,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic [1:0] m_tuser,
  output logic       m_tlast
);

  result_t    out_r;
  result_t    rem0, rem1;
  logic [1:0] rem_cnt;
  logic       slot_free;

  assign slot_free      = !m_tvalid || m_tready;
  assign stat.load_ok   = slot_free && (rem_cnt == 2'd0);
  assign stat.pend_busy = (rem_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      rem_cnt  <= 2'd0;
    end else if (slot_free) begin
      if (rem_cnt != 2'd0) begin
        m_tvalid <= 1'b1;
        rem_cnt  <= rem_cnt - 2'd1;
      end else if (load && bundle.cnt != 2'd0) begin
        m_tvalid <= 1'b1;
        rem_cnt  <= bundle.cnt - 2'd1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload: drain leftovers first, then take a fresh bundle
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (rem_cnt != 2'd0) begin
        out_r <= rem0;
        rem0  <= rem1;
      end else if (load) begin
        out_r <= bundle.r0;
        rem0  <= bundle.r1;
        rem1  <= bundle.r2;
      end
    end
  end

  assign m_tdata = out_r.out_byte;
  assign m_tuser = {out_r.bad_escape, out_r.byte_valid};
  assign m_tlast = out_r.last_of_run;

endmodule
